// ===== hw/rtl/bcpg_pkg.sv =====
package bcpg_pkg;

    // Table and frame geometry
    localparam int TABLE_BITS      = 14;
    localparam int ITERATION_TOTAL = 256;
    localparam int CURVE_TOTAL     = 256;
    localparam int CURVE_STRIDE    = 4;
    localparam int VIEW_SIZE       = 320;

    localparam int TABLE_N   = 1 << TABLE_BITS;
    localparam int HALF_N    = TABLE_N / 2;
    localparam int QTR       = TABLE_N / 4;
    localparam int QTR_N     = QTR + 1;
    localparam int QIDX_W    = TABLE_BITS - 1;
    localparam int HALF_VIEW = VIEW_SIZE / 2;

    localparam int CURVE_COUNT = (CURVE_TOTAL + CURVE_STRIDE - 1) / CURVE_STRIDE;
    localparam int CURVE_W     = $clog2(CURVE_COUNT);
    localparam int ITER_W      = $clog2(ITERATION_TOTAL);

    // 2*pi with 30 fraction bits
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam int ANGLE_ONE_DIV = 235;
    localparam int ANGLE_ONE_STEP = (CURVE_STRIDE << TABLE_BITS) / ANGLE_ONE_DIV;
    localparam longint unsigned ANGLE_TWO_FULL =
        (64'(CURVE_STRIDE) << (TABLE_BITS + 30)) / TWO_PI_Q30;

    // Field widths
    localparam int ANIM_W     = 14;
    localparam int SIZE_W     = 21;
    localparam int OFFSET_W   = 14;
    localparam int SCREEN_W   = 9;
    localparam int COLOR_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam int SIZE_RESET = 65536;

    // Datapath widths
    localparam int COORD_W     = TABLE_BITS;
    localparam int SINE_W      = TABLE_BITS - 1;
    localparam int MAG_W       = SINE_W - 1;
    localparam int SCALE_MUL   = int'((64'(VIEW_SIZE) * 64'd157079633) / 64'd100000000);
    localparam int SCALE_MUL_W = $clog2(SCALE_MUL + 1) + 1;
    localparam int MUL1_W      = COORD_W + SCALE_MUL_W;
    localparam int PROD_W      = MUL1_W + SIZE_W + 1;
    localparam int TRUNC_SHIFT = 16;
    localparam int FLOOR_SHIFT = 14;
    localparam int TRUNC_BIAS  = (1 << TRUNC_SHIFT) - 1;
    localparam int FLOOR_W     = PROD_W - TRUNC_SHIFT - FLOOR_SHIFT;
    localparam int POS_W       = ((FLOOR_W > OFFSET_W) ? FLOOR_W : OFFSET_W) + 1;
    localparam int CMUL_W      = CURVE_W + 5;
    localparam int ITER_COLOR_SHIFT = 4;
    localparam logic [COLOR_W-1:0] COLOR_HI_MASK = 7'h70;

    localparam logic [63:0] SERIES_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic        [TABLE_BITS-1:0] t_angle;
    typedef logic signed [SINE_W-1:0]     t_sine;
    typedef logic signed [COORD_W-1:0]    t_coord;
    typedef logic        [SIZE_W-1:0]     t_size;
    typedef logic signed [OFFSET_W-1:0]   t_offset;

    typedef struct packed {
        t_coord               nx;
        t_coord               ny;
        logic [COLOR_W-1:0]   color;
        logic                 last;
    } t_point;

    typedef enum logic [1:0] {
        F_IDLE,
        F_COS,
        F_SUM
    } t_walk_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_SCALE = 2'd0,
        CFG_X_OFFSET   = 2'd1,
        CFG_Y_OFFSET   = 2'd2
    } t_cfg_reg;

    // First-quadrant sine magnitude, evaluated at elaboration
    function automatic logic [MAG_W-1:0] sine_quarter(input int unsigned r);
        logic [63:0] th;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        th   = (64'(r) * TWO_PI_Q30) >> TABLE_BITS;
        sum  = th;
        term = th;
        for (int k = 1; k <= 12; k++) begin
            term = (((term * th) >> 30) * th) >> 30;
            term = term / SERIES_DIV[k];
            if (k[0]) sum = sum - term;
            else      sum = sum + term;
        end
        val = (sum * 64'(TABLE_N)) / TWO_PI_Q30;
        return MAG_W'(val);
    endfunction

endpackage

// ===== hw/rtl/bcpg_if.sv =====
interface bcpg_in_if import bcpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_frame;
    logic [ANIM_W-1:0] anim_time;

    modport source (output valid, start_frame, anim_time, input ready);
    modport sink   (input valid, start_frame, anim_time, output ready);
endinterface

interface bcpg_out_if import bcpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic                in_view;
    logic [COLOR_W-1:0]  color_index;
    logic                last_of_frame;

    modport source (output valid, screen_x, screen_y, in_view, color_index, last_of_frame,
                    input ready);
    modport sink   (input valid, screen_x, screen_y, in_view, color_index, last_of_frame,
                    output ready);
endinterface

interface bcpg_cfg_if import bcpg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bcpg_sine_rom.sv =====
module bcpg_sine_rom import bcpg_pkg::*; (
    input  logic   i_clk,
    input  t_angle i_addr_a,
    input  t_angle i_addr_b,
    output t_sine  o_data_a,
    output t_sine  o_data_b
);

    typedef struct packed {
        logic              neg;
        logic [QIDX_W-1:0] idx;
    } t_fold;

    logic [MAG_W-1:0] w_qtab [QTR_N];
    t_fold            w_fa;
    t_fold            w_fb;
    t_sine            r_data_a;
    t_sine            r_data_b;

    for (genvar g = 0; g < QTR_N; g++) begin : g_qtab
        localparam logic [MAG_W-1:0] QVAL = sine_quarter(g);
        assign w_qtab[g] = QVAL;
    end

    // Fold the angle into the first quadrant; second half of the circle negates
    function automatic t_fold fold_addr(input t_angle a);
        t_fold             f;
        logic [QIDX_W-1:0] r;
        r     = a[QIDX_W-1:0];
        f.neg = a[TABLE_BITS-1];
        if (r > QIDX_W'(QTR)) f.idx = QIDX_W'(HALF_N) - r;
        else                  f.idx = r;
        return f;
    endfunction

    assign w_fa = fold_addr(i_addr_a);
    assign w_fb = fold_addr(i_addr_b);

    always_ff @(posedge i_clk) begin
        r_data_a <= w_fa.neg ? -t_sine'({1'b0, w_qtab[w_fa.idx]})
                             :  t_sine'({1'b0, w_qtab[w_fa.idx]});
        r_data_b <= w_fb.neg ? -t_sine'({1'b0, w_qtab[w_fb.idx]})
                             :  t_sine'({1'b0, w_qtab[w_fb.idx]});
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== hw/rtl/bcpg_walker.sv =====
module bcpg_walker import bcpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcpg_in_if.sink    i_in,
    output t_angle     o_addr_a,
    output t_angle     o_addr_b,
    input  t_sine      i_data_a,
    input  t_sine      i_data_b,
    output logic       o_push,
    output t_point     o_point,
    input  logic       i_room
);

    t_walk_state r_state, n_state;
    t_angle      r_a1, n_a1;
    t_angle      r_a2, n_a2;
    t_coord      r_cx, n_cx;
    t_coord      r_cy, n_cy;
    logic [CURVE_W-1:0] r_curve, n_curve;
    logic [ITER_W-1:0]  r_iter, n_iter;
    t_angle      r_i1;
    t_angle      r_i2;
    t_coord      r_nx;

    logic        w_accept;
    t_angle      w_a1;
    t_angle      w_a2;
    t_coord      w_x;
    t_coord      w_y;
    t_angle      w_i1;
    t_angle      w_i2;
    t_coord      w_ny;
    logic [CMUL_W-1:0]  w_cmul;
    logic [COLOR_W-1:0] w_color;
    logic        w_last;
    logic        w_advance;

    assign w_accept = (r_state == F_IDLE) && i_in.valid;

    // A frame restart overrides the stored walk before the addresses are formed
    assign w_a1 = i_in.start_frame ? TABLE_BITS'(i_in.anim_time) : r_a1;
    assign w_a2 = i_in.start_frame ? TABLE_BITS'(i_in.anim_time) : r_a2;
    assign w_x  = i_in.start_frame ? '0 : r_cx;
    assign w_y  = i_in.start_frame ? '0 : r_cy;
    assign w_i1 = w_a1 + t_angle'(w_x);
    assign w_i2 = w_a2 + t_angle'(w_y);

    assign w_ny = t_coord'(i_data_a) + t_coord'(i_data_b);

    assign w_cmul  = CMUL_W'(r_curve) * CMUL_W'(CURVE_STRIDE);
    assign w_color = (COLOR_W'(w_cmul >> 1) & COLOR_HI_MASK)
                   + COLOR_W'(r_iter >> ITER_COLOR_SHIFT);
    assign w_last  = (r_curve == CURVE_W'(CURVE_COUNT - 1))
                  && (r_iter == ITER_W'(ITERATION_TOTAL - 1));

    assign w_advance = (r_state == F_SUM) && i_room;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_in.valid) n_state = F_COS;
            F_COS:  n_state = F_SUM;
            F_SUM:  if (i_room) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        o_push     = 1'b0;
        o_addr_a   = r_i1 + t_angle'(QTR);
        o_addr_b   = r_i2 + t_angle'(QTR);
        case (r_state)
            F_IDLE: begin
                i_in.ready = 1'b1;
                o_addr_a   = w_i1;
                o_addr_b   = w_i2;
            end
            F_COS: begin
            end
            F_SUM: begin
                o_push = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_curve = r_curve;
        n_iter  = r_iter;
        if (w_accept) begin
            n_a1 = w_a1;
            n_a2 = w_a2;
            n_cx = w_x;
            n_cy = w_y;
            if (i_in.start_frame) begin
                n_curve = '0;
                n_iter  = '0;
            end
        end else if (w_advance) begin
            if (r_iter == ITER_W'(ITERATION_TOTAL - 1)) begin
                // end of curve: restart at the origin with the next angle starts
                n_iter = '0;
                n_cx   = '0;
                n_cy   = '0;
                n_a1   = r_a1 + t_angle'(ANGLE_ONE_STEP);
                n_a2   = r_a2 + t_angle'(ANGLE_TWO_FULL);
                if (r_curve == CURVE_W'(CURVE_COUNT - 1)) n_curve = '0;
                else n_curve = r_curve + 1'b1;
            end else begin
                n_iter = r_iter + 1'b1;
                n_cx   = r_nx;
                n_cy   = w_ny;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_a1    <= '0;
            r_a2    <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_curve <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_a1    <= n_a1;
            r_a2    <= n_a2;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_curve <= n_curve;
            r_iter  <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_i1 <= w_i1;
            r_i2 <= w_i2;
        end
        if (r_state == F_COS) begin
            r_nx <= t_coord'(i_data_a) + t_coord'(i_data_b);
        end
    end

    assign o_point = '{nx: r_nx, ny: w_ny, color: w_color, last: w_last};

endmodule

// ===== hw/rtl/bcpg_scaler.sv =====
module bcpg_scaler import bcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_point      i_point,
    output logic        o_room,
    input  t_size       i_size_scale,
    input  t_offset     i_x_offset,
    input  t_offset     i_y_offset,
    bcpg_out_if.source  o_out
);

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_meta;

    localparam logic signed [PROD_W-1:0] BIAS     = PROD_W'(TRUNC_BIAS);
    localparam logic signed [POS_W-1:0]  HALF_POS = POS_W'(HALF_VIEW);

    logic                      r1_v, r2_v, r3_v, r_ov;
    logic signed [MUL1_W-1:0]  r1_vx, r1_vy;
    logic signed [PROD_W-1:0]  r2_px, r2_py;
    logic signed [FLOOR_W-1:0] r3_fx, r3_fy;
    t_meta                     r1_m, r2_m, r3_m;
    logic [SCREEN_W-1:0]       r_ox, r_oy;
    logic                      r_oview;
    t_meta                     r_om;

    logic                      w_ld1, w_ld2, w_ld3, w_ldo;
    logic signed [PROD_W-1:0]  w_bx, w_by;
    logic signed [POS_W-1:0]   w_xpos, w_ypos;
    logic                      w_view;

    // Each stage takes a new item when empty or when its item moves on
    assign w_ldo = !r_ov || o_out.ready;
    assign w_ld3 = !r3_v || w_ldo;
    assign w_ld2 = !r2_v || w_ld3;
    assign w_ld1 = !r1_v || w_ld2;
    assign o_room = w_ld1;

    // Truncate toward zero by 2^16, then floor by 2^14: one arithmetic shift
    assign w_bx = r2_px[PROD_W-1] ? r2_px + BIAS : r2_px;
    assign w_by = r2_py[PROD_W-1] ? r2_py + BIAS : r2_py;

    assign w_xpos = POS_W'(r3_fx) + POS_W'(i_x_offset);
    assign w_ypos = POS_W'(r3_fy) + POS_W'(i_y_offset);
    assign w_view = (w_xpos > -HALF_POS) && (w_xpos < HALF_POS)
                 && (w_ypos > -HALF_POS) && (w_ypos < HALF_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ld1) r1_v <= i_push;
            if (w_ld2) r2_v <= r1_v;
            if (w_ld3) r3_v <= r2_v;
            if (w_ldo) r_ov <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1 && i_push) begin
            r1_vx <= MUL1_W'(i_point.nx) * MUL1_W'(SCALE_MUL);
            r1_vy <= MUL1_W'(i_point.ny) * MUL1_W'(SCALE_MUL);
            r1_m  <= '{color: i_point.color, last: i_point.last};
        end
        if (w_ld2 && r1_v) begin
            r2_px <= PROD_W'(r1_vx) * PROD_W'($signed({1'b0, i_size_scale}));
            r2_py <= PROD_W'(r1_vy) * PROD_W'($signed({1'b0, i_size_scale}));
            r2_m  <= r1_m;
        end
        if (w_ld3 && r2_v) begin
            r3_fx <= FLOOR_W'(w_bx >>> (TRUNC_SHIFT + FLOOR_SHIFT));
            r3_fy <= FLOOR_W'(w_by >>> (TRUNC_SHIFT + FLOOR_SHIFT));
            r3_m  <= r2_m;
        end
        if (w_ldo && r3_v) begin
            r_ox    <= w_view ? SCREEN_W'(w_xpos + HALF_POS) : '0;
            r_oy    <= w_view ? SCREEN_W'(w_ypos + HALF_POS) : '0;
            r_oview <= w_view;
            r_om    <= r3_m;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.screen_x      = r_ox;
    assign o_out.screen_y      = r_oy;
    assign o_out.in_view       = r_oview;
    assign o_out.color_index   = r_om.color;
    assign o_out.last_of_frame = r_om.last;

endmodule

// ===== hw/rtl/bubble_curve_point_generator.sv =====
// Bubble-universe curve point generator.
// i_in carries one step item (start_frame, anim_time); each accepted item yields
// exactly one point item on o_out (screen_x, screen_y, in_view, color_index,
// last_of_frame). i_cfg writes size_scale (index 0), x_offset (1), y_offset (2);
// it is always ready, and writes are meant for times when no item is in flight.
// Step items are taken one at a time: the walker accepts the next only after it has
// pushed the last point into the scaler. It reads the sine table at the sine
// addresses, then at the cosine addresses, then sums; the next step's addresses come
// from that sum, so this loop through the table's two read ports sets the pace.
// Path to o_out: the walker's F_COS and F_SUM states, then the scaling pipeline
// registers r1, r2 and r3, then the output register.
// Reset (synchronous, active low) clears the walk to curve 0, iteration 0, angle
// starts 0, restores the default zoom and pan and empties the pipeline; the sine
// table is a fixed ROM and needs no clearing.
// When o_out is stalled the scaling pipeline fills up, then the walker holds its
// finished point and i_in.ready stays low until room opens; nothing is dropped.
module bubble_curve_point_generator import bcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcpg_cfg_if.sink    i_cfg,
    bcpg_in_if.sink     i_in,
    bcpg_out_if.source  o_out
);

    t_size   r_size_scale;
    t_offset r_x_offset;
    t_offset r_y_offset;

    t_angle  w_addr_a;
    t_angle  w_addr_b;
    t_sine   w_data_a;
    t_sine   w_data_b;
    logic    w_push;
    logic    w_room;
    t_point  w_point;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_scale <= SIZE_W'(SIZE_RESET);
            r_x_offset   <= '0;
            r_y_offset   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SIZE_SCALE: r_size_scale <= i_cfg.data[SIZE_W-1:0];
                CFG_X_OFFSET:   r_x_offset   <= $signed(i_cfg.data[OFFSET_W-1:0]);
                CFG_Y_OFFSET:   r_y_offset   <= $signed(i_cfg.data[OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    bcpg_sine_rom u_rom (
        .i_clk    (i_clk),
        .i_addr_a (w_addr_a),
        .i_addr_b (w_addr_b),
        .o_data_a (w_data_a),
        .o_data_b (w_data_b)
    );

    bcpg_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_addr_a (w_addr_a),
        .o_addr_b (w_addr_b),
        .i_data_a (w_data_a),
        .i_data_b (w_data_b),
        .o_push   (w_push),
        .o_point  (w_point),
        .i_room   (w_room)
    );

    bcpg_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_point      (w_point),
        .o_room       (w_room),
        .i_size_scale (r_size_scale),
        .i_x_offset   (r_x_offset),
        .i_y_offset   (r_y_offset),
        .o_out        (o_out)
    );

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.in_view) |-> (o_out.screen_x == '0 && o_out.screen_y == '0))
        else $error("point outside view has nonzero coordinates");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("step item accepted while another is in the walker");

    a_hold_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_room) |=> (w_push && $stable(w_point)))
        else $error("walker dropped or changed a point the scaler did not take");

endmodule
